FILE: design/blse_pkg.sv
// Shared types, codes and widths for the bounded list store engine.
package blse_pkg;

  // Field widths fixed by the interface.
  localparam int VAL_W        = 31;
  localparam int KIND_W       = 3;
  localparam int STATUS_W     = 2;
  localparam int FIDX_W       = 7;
  localparam int CNT_OUT_W    = 8;
  localparam int CAPACITY_DEF = 128;

  // Operation codes carried by a request.
  typedef enum logic [KIND_W-1:0] {
    K_APPEND    = 3'd0,
    K_REMOVE    = 3'd1,
    K_FIND      = 3'd2,
    K_SORT_ASC  = 3'd3,
    K_SORT_DESC = 3'd4,
    K_EXTREMES  = 3'd5
  } kind_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_REM,
    S_WALK_RD,
    S_WALK_CMP,
    S_WALK_MAX,
    S_SORT_KEY_RD,
    S_SORT_KEY,
    S_SORT_PREV,
    S_SORT_CMP
  } state_t;

  // Flags from the shared magnitude comparator.
  typedef struct packed {
    logic lt;
    logic gt;
    logic eq;
  } cmp_res_t;

endpackage

FILE: design/bounded_list_store_engine_unit.sv
// Top level: request sequencer, element store and shared comparator.
//
//  channel  | ports                              | handshake
//  ---------+------------------------------------+-------------------------------
//  request  | in_kind, in_operand_value          | taken when start and !busy
//  result   | out_status ... out_is_full         | out_valid high for one cycle
//
// Append, unused codes and refused requests are answered straight from idle;
// remove reads the last element; find and extremes walk the list element by
// element, all through the one read port and comparator. Sort (insertion)
// reads each key, shifts the elements that must move up one by one and drops
// the key into the hole.
// Reset clears the state, the count and out_valid only; the receiver cannot stall, a result shows one cycle.
module bounded_list_store_engine_unit #(
  parameter int CAPACITY = blse_pkg::CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [blse_pkg::KIND_W-1:0]    in_kind,
  input  logic [blse_pkg::VAL_W-1:0]     in_operand_value,
  output logic                           out_valid,
  output logic [blse_pkg::STATUS_W-1:0]  out_status,
  output logic [blse_pkg::FIDX_W-1:0]    out_found_index,
  output logic [blse_pkg::VAL_W-1:0]     out_removed_value,
  output logic [blse_pkg::VAL_W-1:0]     out_min_value,
  output logic [blse_pkg::VAL_W-1:0]     out_max_value,
  output logic                           out_all_even,
  output logic [blse_pkg::CNT_OUT_W-1:0] out_element_count,
  output logic                           out_is_empty,
  output logic                           out_is_full
);

  import blse_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  // Control state.
  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            ov_r, ov_nxt;

  // Working registers.
  kind_t           kind_r, kind_nxt;
  logic [VAL_W-1:0] opv_r, opv_nxt;
  logic [CW-1:0]   i_r, i_nxt;
  logic [CW-1:0]   j_r, j_nxt;
  logic [VAL_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] min_r, min_nxt;
  logic [VAL_W-1:0] max_r, max_nxt;
  logic            even_r, even_nxt;

  // Result registers.
  status_t         status_r, status_nxt;
  logic [FIDX_W-1:0] fidx_r, fidx_nxt;
  logic [VAL_W-1:0] rem_r, rem_nxt;
  logic [VAL_W-1:0] omin_r, omin_nxt;
  logic [VAL_W-1:0] omax_r, omax_nxt;
  logic            oeven_r, oeven_nxt;

  // Store and comparator connections.
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [VAL_W-1:0] ram_wdata, ram_rdata;
  logic [VAL_W-1:0] cmp_b;
  cmp_res_t        cmp_res;

  logic [CW-1:0]   cnt_dec, j_dec, i_inc;
  logic            list_empty, list_full, move;

  assign cnt_dec    = count_r - CW'(1);
  assign j_dec      = j_r - CW'(1);
  assign i_inc      = i_r + CW'(1);
  assign list_empty = (count_r == '0);
  assign list_full  = (count_r == CW'(CAPACITY));
  assign move       = (kind_r == K_SORT_ASC) ? cmp_res.gt : cmp_res.lt;

  blse_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  blse_cmp u_cmp (
    .a   (ram_rdata),
    .b   (cmp_b),
    .res (cmp_res)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    opv_r    <= opv_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    key_r    <= key_nxt;
    min_r    <= min_nxt;
    max_r    <= max_nxt;
    even_r   <= even_nxt;
    status_r <= status_nxt;
    fidx_r   <= fidx_nxt;
    rem_r    <= rem_nxt;
    omin_r   <= omin_nxt;
    omax_r   <= omax_nxt;
    oeven_r  <= oeven_nxt;
  end

  // Sequencer: next state, store accesses and comparator operand.
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    ov_nxt     = 1'b0;
    kind_nxt   = kind_r;
    opv_nxt    = opv_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    key_nxt    = key_r;
    min_nxt    = min_r;
    max_nxt    = max_r;
    even_nxt   = even_r;
    status_nxt = status_r;
    fidx_nxt   = fidx_r;
    rem_nxt    = rem_r;
    omin_nxt   = omin_r;
    omax_nxt   = omax_r;
    oeven_nxt  = oeven_r;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    cmp_b      = opv_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          kind_nxt   = kind_t'(in_kind);
          opv_nxt    = in_operand_value;
          i_nxt      = '0;
          status_nxt = ST_OK;
          fidx_nxt   = '0;
          rem_nxt    = '0;
          omin_nxt   = '0;
          omax_nxt   = '0;
          oeven_nxt  = 1'b0;
          case (kind_t'(in_kind))
            K_APPEND: begin
              ov_nxt = 1'b1;
              if (list_full) begin
                status_nxt = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = count_r[AW-1:0];
                ram_wdata = in_operand_value;
                count_nxt = count_r + CW'(1);
              end
            end
            K_REMOVE: begin
              if (list_empty) begin
                ov_nxt     = 1'b1;
                status_nxt = ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = cnt_dec[AW-1:0];
                count_nxt = cnt_dec;
                state_nxt = S_REM;
              end
            end
            K_FIND: begin
              state_nxt = S_WALK_RD;
            end
            K_SORT_ASC, K_SORT_DESC: begin
              i_nxt     = CW'(1);
              state_nxt = S_SORT_KEY_RD;
            end
            K_EXTREMES: begin
              if (list_empty) begin
                ov_nxt     = 1'b1;
                status_nxt = ST_EMPTY;
                oeven_nxt  = 1'b1;
              end else begin
                even_nxt  = 1'b1;
                state_nxt = S_WALK_RD;
              end
            end
            default: begin
              ov_nxt = 1'b1;
            end
          endcase
        end
      end

      // Removed value arrives from the store.
      S_REM: begin
        ov_nxt    = 1'b1;
        rem_nxt   = ram_rdata;
        state_nxt = S_IDLE;
      end

      // Walk over the list for find and extremes.
      S_WALK_RD: begin
        if (i_r == count_r) begin
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
          if (kind_r == K_FIND) begin
            status_nxt = ST_MISS;
          end else begin
            omin_nxt  = min_r;
            omax_nxt  = max_r;
            oeven_nxt = even_r;
          end
        end else begin
          ram_re    = 1'b1;
          ram_raddr = i_r[AW-1:0];
          state_nxt = S_WALK_CMP;
        end
      end

      S_WALK_CMP: begin
        if (kind_r == K_FIND) begin
          cmp_b = opv_r;
          if (cmp_res.eq) begin
            ov_nxt    = 1'b1;
            fidx_nxt  = FIDX_W'(i_r);
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = i_inc;
            state_nxt = S_WALK_RD;
          end
        end else begin
          cmp_b = min_r;
          if ((i_r == '0) || cmp_res.lt) begin
            min_nxt = ram_rdata;
          end
          if (ram_rdata[0]) begin
            even_nxt = 1'b0;
          end
          state_nxt = S_WALK_MAX;
        end
      end

      S_WALK_MAX: begin
        cmp_b = max_r;
        if ((i_r == '0) || cmp_res.gt) begin
          max_nxt = ram_rdata;
        end
        i_nxt     = i_inc;
        state_nxt = S_WALK_RD;
      end

      // Insertion sort: fetch the next key.
      S_SORT_KEY_RD: begin
        if (i_r >= count_r) begin
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = i_r[AW-1:0];
          state_nxt = S_SORT_KEY;
        end
      end

      S_SORT_KEY: begin
        key_nxt   = ram_rdata;
        j_nxt     = i_r;
        state_nxt = S_SORT_PREV;
      end

      // Place the key at the front, or read the element before the hole.
      S_SORT_PREV: begin
        if (j_r == '0) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = key_r;
          i_nxt     = i_inc;
          state_nxt = S_SORT_KEY_RD;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = j_dec[AW-1:0];
          state_nxt = S_SORT_CMP;
        end
      end

      // Shift the previous element up, or drop the key into the hole.
      S_SORT_CMP: begin
        cmp_b    = key_r;
        ram_we   = 1'b1;
        ram_waddr = j_r[AW-1:0];
        if (move) begin
          ram_wdata = ram_rdata;
          j_nxt     = j_dec;
          state_nxt = S_SORT_PREV;
        end else begin
          ram_wdata = key_r;
          i_nxt     = i_inc;
          state_nxt = S_SORT_KEY_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Outputs.
  assign busy              = (state_r != S_IDLE);
  assign out_valid         = ov_r;
  assign out_status        = status_r;
  assign out_found_index   = fidx_r;
  assign out_removed_value = rem_r;
  assign out_min_value     = omin_r;
  assign out_max_value     = omax_r;
  assign out_all_even      = oeven_r;
  assign out_element_count = CNT_OUT_W'(count_r);
  assign out_is_empty      = list_empty;
  assign out_is_full       = list_full;

endmodule

FILE: design/blse_ram.sv
// Generic single-write, single-read RAM with registered read data.
module blse_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/blse_cmp.sv
// Shared magnitude comparator used by find, extremes and sort.
module blse_cmp (
  input  logic [blse_pkg::VAL_W-1:0] a,
  input  logic [blse_pkg::VAL_W-1:0] b,
  output blse_pkg::cmp_res_t         res
);

  import blse_pkg::*;

  // One unsigned compare of a against b.
  always_comb begin
    res.lt = (a < b);
    res.gt = (a > b);
    res.eq = (a == b);
  end

endmodule

FILE: dv/blse_result_checker.sv
// Result checker for the bounded list store engine: predicts every request and compares.
module blse_result_checker #(
  parameter int CAPACITY = blse_pkg::CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic [blse_pkg::KIND_W-1:0]    in_kind,
  input  logic [blse_pkg::VAL_W-1:0]     in_operand_value,
  input  logic                           out_valid,
  input  logic [blse_pkg::STATUS_W-1:0]  out_status,
  input  logic [blse_pkg::FIDX_W-1:0]    out_found_index,
  input  logic [blse_pkg::VAL_W-1:0]     out_removed_value,
  input  logic [blse_pkg::VAL_W-1:0]     out_min_value,
  input  logic [blse_pkg::VAL_W-1:0]     out_max_value,
  input  logic                           out_all_even,
  input  logic [blse_pkg::CNT_OUT_W-1:0] out_element_count,
  input  logic                           out_is_empty,
  input  logic                           out_is_full,
  output int                             fail_count,
  output int                             pending,
  output int                             results_checked
);

  import blse_pkg::*;

  typedef struct {
    status_t                status;
    logic [FIDX_W-1:0]      found_index;
    logic [VAL_W-1:0]       removed_value;
    logic [VAL_W-1:0]       min_value;
    logic [VAL_W-1:0]       max_value;
    logic                   all_even;
    logic [CNT_OUT_W-1:0]   element_count;
    logic                   is_empty;
    logic                   is_full;
  } list_result_t;

  // Shadow copy of the list and the results still owed by the block.
  logic [VAL_W-1:0] list_mem [CAPACITY];
  int               list_len;
  list_result_t     expected_q [$];

  initial begin
    fail_count      = 0;
    pending         = 0;
    results_checked = 0;
    list_len        = 0;
  end

  // Applies one request to the shadow list and returns the result it should give.
  function automatic list_result_t predict_request(logic [KIND_W-1:0] kind,
                                                   logic [VAL_W-1:0] value);
    list_result_t     r;
    int               i;
    int               j;
    logic [VAL_W-1:0] key;
    logic             hit;
    logic             ascending;
    r.status        = ST_OK;
    r.found_index   = '0;
    r.removed_value = '0;
    r.min_value     = '0;
    r.max_value     = '0;
    r.all_even      = 1'b0;
    hit             = 1'b0;
    ascending       = (kind == K_SORT_ASC);
    case (kind)
      K_APPEND: begin
        if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          list_mem[list_len] = value;
          list_len++;
        end
      end
      K_REMOVE: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          list_len--;
          r.removed_value = list_mem[list_len];
        end
      end
      K_FIND: begin
        r.status = ST_MISS;
        for (i = 0; i < list_len && !hit; i++) begin
          if (list_mem[i] == value) begin
            hit           = 1'b1;
            r.status      = ST_OK;
            r.found_index = FIDX_W'(i);
          end
        end
      end
      K_SORT_ASC, K_SORT_DESC: begin
        // Insertion sort in place; equal values never move past each other.
        for (i = 1; i < list_len; i++) begin
          key = list_mem[i];
          j   = i;
          while (j > 0 && (ascending ? (list_mem[j-1] > key) : (list_mem[j-1] < key))) begin
            list_mem[j] = list_mem[j-1];
            j--;
          end
          list_mem[j] = key;
        end
      end
      K_EXTREMES: begin
        // An empty list still reports all-even.
        r.all_even = 1'b1;
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.min_value = list_mem[0];
          r.max_value = list_mem[0];
          for (i = 0; i < list_len; i++) begin
            if (list_mem[i] > r.max_value) r.max_value = list_mem[i];
            if (list_mem[i] < r.min_value) r.min_value = list_mem[i];
            if (list_mem[i][0]) r.all_even = 1'b0;
          end
        end
      end
      default: begin
        // Spare codes do nothing and report only the count and flags.
      end
    endcase
    r.element_count = CNT_OUT_W'(list_len);
    r.is_empty      = (list_len == 0);
    r.is_full       = (list_len == CAPACITY);
    return r;
  endfunction

  function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, want, got);
      fail_count++;
    end
  endfunction

  // Compare each result with the oldest prediction, then record any new request.
  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      list_len = 0;
      expected_q.delete();
    end else begin
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with no request outstanding, expected none, actual status %0d",
                   $time, out_status);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("found_index", 32'(want.found_index), 32'(out_found_index));
          check_field("removed_value", 32'(want.removed_value), 32'(out_removed_value));
          check_field("min_value", 32'(want.min_value), 32'(out_min_value));
          check_field("max_value", 32'(want.max_value), 32'(out_max_value));
          check_field("all_even", 32'(want.all_even), 32'(out_all_even));
          check_field("element_count", 32'(want.element_count), 32'(out_element_count));
          check_field("is_empty", 32'(want.is_empty), 32'(out_is_empty));
          check_field("is_full", 32'(want.is_full), 32'(out_is_full));
          results_checked++;
        end
      end
      if (start && !busy) begin
        expected_q.push_back(predict_request(in_kind, in_operand_value));
      end
    end
    pending <= expected_q.size();
  end

endmodule

FILE: dv/tb_bounded_list_store_engine_unit.sv
// Testbench top for the bounded list store engine: request stimulus and the verdict.
module tb_bounded_list_store_engine_unit;
  import blse_pkg::*;

  localparam int                CAP           = CAPACITY_DEF;
  localparam int                REQUEST_GOAL  = 1200;
  localparam int                CYCLE_LIMIT   = 2_500_000;
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
  localparam logic [VAL_W-1:0]  VAL_MAX       = '1;

  typedef enum int {
    VALS_SMALL,
    VALS_WIDE,
    VALS_EVEN
  } value_mode_t;

  logic                 clk              = 1'b0;
  logic                 rst_n            = 1'b0;
  logic                 start            = 1'b0;
  logic [KIND_W-1:0]    in_kind          = '0;
  logic [VAL_W-1:0]     in_operand_value = '0;
  logic                 busy;
  logic                 out_valid;
  logic [STATUS_W-1:0]  out_status;
  logic [FIDX_W-1:0]    out_found_index;
  logic [VAL_W-1:0]     out_removed_value;
  logic [VAL_W-1:0]     out_min_value;
  logic [VAL_W-1:0]     out_max_value;
  logic                 out_all_even;
  logic [CNT_OUT_W-1:0] out_element_count;
  logic                 out_is_empty;
  logic                 out_is_full;

  int fail_count;
  int pending;
  int results_checked;
  int cycle_count  = 0;
  int n_requests   = 0;
  int n_full_fills = 0;
  int sort_budget  = 0;
  bit no_idle      = 1'b0;

  // Values currently in the list, kept only to steer lengths and pick search hits.
  logic [VAL_W-1:0] stored_vals [$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  bounded_list_store_engine_unit #(.CAPACITY(CAP)) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_operand_value  (in_operand_value),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_found_index   (out_found_index),
    .out_removed_value (out_removed_value),
    .out_min_value     (out_min_value),
    .out_max_value     (out_max_value),
    .out_all_even      (out_all_even),
    .out_element_count (out_element_count),
    .out_is_empty      (out_is_empty),
    .out_is_full       (out_is_full)
  );

  blse_result_checker #(.CAPACITY(CAP)) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_operand_value  (in_operand_value),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_found_index   (out_found_index),
    .out_removed_value (out_removed_value),
    .out_min_value     (out_min_value),
    .out_max_value     (out_max_value),
    .out_all_even      (out_all_even),
    .out_element_count (out_element_count),
    .out_is_empty      (out_is_empty),
    .out_is_full       (out_is_full),
    .fail_count        (fail_count),
    .pending           (pending),
    .results_checked   (results_checked)
  );

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run timed out with %0d results still outstanding.", pending);
      $display("tb_bounded_list_store_engine_unit NOT OK");
      $finish;
    end
  end

  function automatic logic [VAL_W-1:0] pick_value(value_mode_t mode);
    logic [VAL_W-1:0] v;
    int               r;
    r = $urandom_range(0, 19);
    v = VAL_W'($urandom());
    if (r == 0) v = '0;
    else if (r == 1) v = VAL_MAX;
    else if (mode == VALS_SMALL || r < 6) v = VAL_W'($urandom_range(0, 15));
    if (mode == VALS_EVEN) v[0] = 1'b0;
    return v;
  endfunction

  // Holds one request until the block takes it, then, unless no_idle is set, idles for a random gap that may be zero.
  task automatic issue_request(logic [KIND_W-1:0] kind, logic [VAL_W-1:0] value);
    int r;
    int gap;
    gap              = 0;
    start            <= 1'b1;
    in_kind          <= kind;
    in_operand_value <= value;
    do @(posedge clk); while (busy);
    n_requests++;
    if (kind == K_APPEND && stored_vals.size() < CAP) stored_vals.push_back(value);
    if (kind == K_REMOVE && stored_vals.size() > 0) void'(stored_vals.pop_back());
    if (!no_idle) begin
      r = $urandom_range(0, 99);
      if (r < 55) gap = 0;
      else if (r < 88) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 15);
      else gap = $urandom_range(25, 70);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending until every outstanding result has come back.
  task automatic wait_for_results();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // One request of a random operation; searches mostly look for stored values.
  task automatic random_op(value_mode_t mode);
    int               r;
    logic [VAL_W-1:0] v;
    r = $urandom_range(0, 99);
    v = pick_value(VALS_WIDE);
    if (r < 30) begin
      issue_request(K_APPEND, pick_value(mode));
    end else if (r < 50) begin
      issue_request(K_REMOVE, v);
    end else if (r < 68) begin
      if (stored_vals.size() > 0 && $urandom_range(0, 3) != 0)
        v = stored_vals[$urandom_range(0, stored_vals.size() - 1)];
      else
        v = pick_value(mode);
      issue_request(K_FIND, v);
    end else if (r < 84) begin
      if (sort_budget > 0) begin
        sort_budget--;
        issue_request((r < 76) ? K_SORT_ASC : K_SORT_DESC, v);
      end else begin
        issue_request(K_EXTREMES, v);
      end
    end else if (r < 96) begin
      issue_request(K_EXTREMES, v);
    end else begin
      issue_request((r < 98) ? KIND_SPARE_LO : KIND_SPARE_HI, v);
    end
  endtask

  // Short list: bring it to a target length, then mixed operations.
  task automatic run_short_episode();
    value_mode_t mode;
    int          target;
    int          n_ops;
    mode        = value_mode_t'($urandom_range(0, 2));
    no_idle     = ($urandom_range(0, 4) == 0);
    sort_budget = 1000;
    target      = $urandom_range(0, 12);
    if (mode == VALS_EVEN || $urandom_range(0, 2) == 0) target = 0;
    while (stored_vals.size() > target) issue_request(K_REMOVE, pick_value(VALS_WIDE));
    target = $urandom_range(0, 12);
    while (stored_vals.size() < target) issue_request(K_APPEND, pick_value(mode));
    n_ops = $urandom_range(8, 24);
    repeat (n_ops) random_op(mode);
    if ($urandom_range(0, 5) == 0) wait_for_results();
  endtask

  // Full list: fill to capacity, work on it with few sorts, then drain most of it.
  task automatic run_full_list_episode();
    value_mode_t mode;
    int          n_ops;
    int          keep_len;
    mode    = ($urandom_range(0, 1) != 0) ? VALS_WIDE : VALS_SMALL;
    no_idle = ($urandom_range(0, 2) == 0);
    while (stored_vals.size() < CAP) issue_request(K_APPEND, pick_value(mode));
    wait_for_results();
    n_full_fills++;
    issue_request(K_APPEND, pick_value(mode));
    issue_request(K_FIND, stored_vals[CAP-1]);
    issue_request(K_EXTREMES, pick_value(VALS_WIDE));
    issue_request(K_SORT_DESC, pick_value(VALS_WIDE));
    issue_request(K_SORT_ASC, pick_value(VALS_WIDE));
    sort_budget = 1;
    n_ops = $urandom_range(6, 12);
    repeat (n_ops) random_op(mode);
    keep_len = $urandom_range(0, 8);
    while (stored_vals.size() > keep_len) issue_request(K_REMOVE, pick_value(VALS_WIDE));
    wait_for_results();
  endtask

  initial begin
    int episode;
    episode = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty-list cases, spare codes, field extremes and every operation.
    issue_request(K_REMOVE, VAL_MAX);
    issue_request(K_EXTREMES, '0);
    issue_request(K_FIND, '0);
    issue_request(K_SORT_ASC, '0);
    issue_request(K_SORT_DESC, VAL_MAX);
    issue_request(KIND_SPARE_LO, VAL_MAX);
    issue_request(KIND_SPARE_HI, '0);
    issue_request(K_APPEND, VAL_MAX);
    issue_request(K_SORT_ASC, '0);
    issue_request(K_FIND, VAL_MAX);
    issue_request(K_EXTREMES, '0);
    issue_request(K_APPEND, '0);
    issue_request(K_APPEND, 31'd2);
    issue_request(K_APPEND, 31'h2AAA_AAAA);
    issue_request(K_APPEND, 31'h5555_5555);
    issue_request(K_FIND, 31'h5555_5555);
    issue_request(K_FIND, 31'd1);
    issue_request(K_SORT_DESC, '0);
    issue_request(K_EXTREMES, '0);
    issue_request(K_SORT_ASC, '0);
    issue_request(K_FIND, VAL_MAX);
    issue_request(K_REMOVE, '0);
    issue_request(K_REMOVE, '0);
    issue_request(K_EXTREMES, '0);
    wait_for_results();

    // Random: mostly short lists, with an occasional trip to a full list.
    while (n_requests < REQUEST_GOAL) begin
      if (episode % 25 == 3) run_full_list_episode();
      else run_short_episode();
      episode++;
    end

    wait_for_results();
    repeat (20) @(posedge clk);
    $display("Ran %0d requests over every operation and both spare codes; %0d results checked.",
             n_requests, results_checked);
    $display("The list was filled to capacity %0d times and sorted, searched and drained there.",
             n_full_fills);
    if (fail_count == 0) begin
      $display("tb_bounded_list_store_engine_unit OK");
    end else begin
      $display("tb_bounded_list_store_engine_unit NOT OK");
    end
    $finish;
  end

endmodule
